>>> rtl/ctee_pkg.sv
// Shared types, codes and constants of the C tokenizer with enum extractor.
package ctee_pkg;

   // Longest source text; positions saturate one below it, or at the field maximum
   localparam int MAX_SOURCE_BYTES = 2097152;
   localparam int POS_W            = 21;
   localparam logic [POS_W-1:0] POS_FIELD_MAX = {POS_W{1'b1}};
   localparam logic [POS_W-1:0] POS_LIMIT =
      (MAX_SOURCE_BYTES - 1 > (1 << POS_W) - 1) ? POS_FIELD_MAX : POS_W'(MAX_SOURCE_BYTES - 1);

   // Token queue between lexer and parser
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Stream widths
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 88;
   localparam int RSP_USER_W = 7;

   // Source characters
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_LF     = 8'h0a;
   localparam logic [7:0] CH_SLASH  = "/";
   localparam logic [7:0] CH_STAR   = "*";
   localparam logic [7:0] CH_BSLASH = "\\";
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_LBRACE = "{";
   localparam logic [7:0] CH_UNDER  = "_";

   // Keywords matched while an identifier is scanned
   localparam logic [7:0] KW_ENUM   [4] = '{"e", "n", "u", "m"};
   localparam logic [7:0] KW_STRUCT [6] = '{"s", "t", "r", "u", "c", "t"};

   // Keyword match progress
   localparam logic [3:0] KM_NONE         = 4'd0;
   localparam logic [3:0] KM_ENUM_FIRST   = 4'd1;
   localparam logic [3:0] KM_ENUM_LAST    = 4'd3;
   localparam logic [3:0] KM_ENUM_DONE    = 4'd4;
   localparam logic [3:0] KM_STRUCT_FIRST = 4'd5;
   localparam logic [3:0] KM_STRUCT_LAST  = 4'd9;
   localparam logic [3:0] KM_STRUCT_DONE  = 4'd10;

   // String text tracking: nothing yet, exactly one brace, anything else
   localparam logic [1:0] SIB_EMPTY = 2'd0;
   localparam logic [1:0] SIB_BRACE = 2'd1;
   localparam logic [1:0] SIB_OTHER = 2'd2;

   typedef enum logic [3:0] {
      TC_LPAREN   = 4'd0,
      TC_RPAREN   = 4'd1,
      TC_LBRACE   = 4'd2,
      TC_RBRACE   = 4'd3,
      TC_LBRACKET = 4'd4,
      TC_RBRACKET = 4'd5,
      TC_COLON    = 4'd6,
      TC_SEMI     = 4'd7,
      TC_STAR     = 4'd8,
      TC_STRING   = 4'd9,
      TC_IDENT    = 4'd10,
      TC_END      = 4'd11,
      TC_UNKNOWN  = 4'd12
   } token_class_type;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_ENUM   = 2'd1,
      KIND_STRUCT = 2'd2,
      KIND_BRACE  = 2'd3
   } token_kind_type;

   typedef enum logic [2:0] {
      ROLE_PLAIN  = 3'd0,
      ROLE_OPEN   = 3'd1,
      ROLE_MEMBER = 3'd2,
      ROLE_CLOSE  = 3'd3,
      ROLE_END    = 3'd4
   } enum_role_type;

   typedef enum logic [2:0] {
      LX_IDLE       = 3'd0,
      LX_SLASH      = 3'd1,
      LX_LINE       = 3'd2,
      LX_BLOCK      = 3'd3,
      LX_BLOCK_STAR = 3'd4,
      LX_STR        = 3'd5,
      LX_STR_ESC    = 3'd6,
      LX_IDENT      = 3'd7
   } lexer_mode_type;

   typedef enum logic [2:0] {
      PM_IDLE         = 3'd0,
      PM_AFTER_ENUM   = 3'd1,
      PM_ENUM_NAMED   = 3'd2,
      PM_ENUM_BODY    = 3'd3,
      PM_AFTER_STRUCT = 3'd4,
      PM_STRUCT_NAMED = 3'd5
   } parser_mode_type;

   typedef struct packed {
      token_class_type   cls;
      token_kind_type    kind;
      logic [POS_W-1:0]  start;
      logic [POS_W-1:0]  len;
   } lex_token_type;

   // Tokens caused by one source byte: one, or two when two is set
   typedef struct packed {
      logic          two;
      lex_token_type tok0;
      lex_token_type tok1;
   } entry_type;

   // Queue handshake toward the parser
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } queue_out_type;

endpackage

>>> rtl/ctee_lexer.sv
// Front part: takes source bytes, tracks positions and cuts them into tokens.
module ctee_lexer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic [7:0]                           source_byte,
   output logic                                 push,
   output ctee_pkg::entry_type                  entry
);

   ctee_pkg::lexer_mode_type        mode_ff, mode_in;
   logic [ctee_pkg::POS_W-1:0]      pos_ff, pos_in;
   logic [ctee_pkg::POS_W-1:0]      pend_ff, pend_in;
   logic [3:0]                      km_ff, km_in;
   logic [1:0]                      sib_ff, sib_in;

   ctee_pkg::lex_token_type         lead_tok, fresh_tok;
   logic                            lead_v, fresh_v;

   function automatic logic [ctee_pkg::POS_W-1:0] sat_inc(input logic [ctee_pkg::POS_W-1:0] p);
      sat_inc = (p >= ctee_pkg::POS_LIMIT) ? ctee_pkg::POS_LIMIT : p + 1'b1;
   endfunction

   function automatic logic [ctee_pkg::POS_W-1:0] span(input logic [ctee_pkg::POS_W-1:0] s,
                                                      input logic [ctee_pkg::POS_W-1:0] p);
      span = (p >= s) ? p - s : '0;
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      is_letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_ident_char(input logic [7:0] c);
      is_ident_char = is_letter(c) || (c >= "0" && c <= "9") || c == ctee_pkg::CH_UNDER;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      is_space = (c == " ") || (c >= 8'd9 && c <= 8'd13);
   endfunction

   // Advance the keyword matcher by one identifier character
   function automatic logic [3:0] km_next(input logic [3:0] km, input logic [7:0] c);
      logic [2:0] sidx;
      sidx = 3'(km - ctee_pkg::KM_ENUM_DONE);
      if (km >= ctee_pkg::KM_ENUM_FIRST && km <= ctee_pkg::KM_ENUM_LAST)
         km_next = (c == ctee_pkg::KW_ENUM[km[1:0]]) ? km + 4'd1 : ctee_pkg::KM_NONE;
      else if (km >= ctee_pkg::KM_STRUCT_FIRST && km <= ctee_pkg::KM_STRUCT_LAST)
         km_next = (c == ctee_pkg::KW_STRUCT[sidx]) ? km + 4'd1 : ctee_pkg::KM_NONE;
      else
         km_next = ctee_pkg::KM_NONE;
   endfunction

   // Next lexer state and the tokens this byte closes or forms
   always_comb begin
      logic fresh;
      logic ended;
      mode_in   = mode_ff;
      pos_in    = pos_ff;
      pend_in   = pend_ff;
      km_in     = km_ff;
      sib_in    = sib_ff;
      lead_v    = 1'b0;
      fresh_v   = 1'b0;
      lead_tok  = '0;
      fresh_tok = '0;
      fresh     = 1'b0;
      ended     = 1'b0;

      unique case (mode_ff)
         ctee_pkg::LX_SLASH: begin
            if (source_byte == ctee_pkg::CH_SLASH) begin
               mode_in = ctee_pkg::LX_LINE;
            end else if (source_byte == ctee_pkg::CH_STAR) begin
               mode_in = ctee_pkg::LX_BLOCK;
            end else begin
               // lone slash
               lead_v         = 1'b1;
               lead_tok.cls   = ctee_pkg::TC_UNKNOWN;
               lead_tok.kind  = ctee_pkg::KIND_NONE;
               lead_tok.start = pend_ff;
               lead_tok.len   = ctee_pkg::POS_W'(1);
               fresh          = 1'b1;
            end
         end
         ctee_pkg::LX_LINE: begin
            if (source_byte == ctee_pkg::CH_NUL) fresh = 1'b1;
            else if (source_byte == ctee_pkg::CH_LF) mode_in = ctee_pkg::LX_IDLE;
         end
         ctee_pkg::LX_BLOCK: begin
            if (source_byte == ctee_pkg::CH_NUL) fresh = 1'b1;
            else if (source_byte == ctee_pkg::CH_STAR) mode_in = ctee_pkg::LX_BLOCK_STAR;
         end
         ctee_pkg::LX_BLOCK_STAR: begin
            if (source_byte == ctee_pkg::CH_NUL) fresh = 1'b1;
            else if (source_byte == ctee_pkg::CH_SLASH) mode_in = ctee_pkg::LX_IDLE;
            else if (source_byte != ctee_pkg::CH_STAR) mode_in = ctee_pkg::LX_BLOCK;
         end
         ctee_pkg::LX_STR, ctee_pkg::LX_STR_ESC: begin
            if (source_byte == ctee_pkg::CH_NUL ||
                (source_byte == ctee_pkg::CH_QUOTE && mode_ff == ctee_pkg::LX_STR)) begin
               lead_v         = 1'b1;
               lead_tok.cls   = ctee_pkg::TC_STRING;
               lead_tok.kind  = (sib_ff == ctee_pkg::SIB_BRACE) ? ctee_pkg::KIND_BRACE
                                                                : ctee_pkg::KIND_NONE;
               lead_tok.start = pend_ff;
               lead_tok.len   = span(pend_ff, pos_ff);
               mode_in        = ctee_pkg::LX_IDLE;
               fresh          = (source_byte == ctee_pkg::CH_NUL);
            end else if (mode_ff == ctee_pkg::LX_STR && source_byte == ctee_pkg::CH_BSLASH) begin
               sib_in  = ctee_pkg::SIB_OTHER;
               mode_in = ctee_pkg::LX_STR_ESC;
            end else begin
               sib_in  = (sib_ff == ctee_pkg::SIB_EMPTY && source_byte == ctee_pkg::CH_LBRACE &&
                          mode_ff == ctee_pkg::LX_STR) ? ctee_pkg::SIB_BRACE
                                                       : ctee_pkg::SIB_OTHER;
               mode_in = ctee_pkg::LX_STR;
            end
         end
         ctee_pkg::LX_IDENT: begin
            if (is_ident_char(source_byte)) begin
               km_in = km_next(km_ff, source_byte);
            end else begin
               lead_v         = 1'b1;
               lead_tok.cls   = ctee_pkg::TC_IDENT;
               lead_tok.kind  = (km_ff == ctee_pkg::KM_ENUM_DONE)   ? ctee_pkg::KIND_ENUM :
                                (km_ff == ctee_pkg::KM_STRUCT_DONE) ? ctee_pkg::KIND_STRUCT :
                                                                      ctee_pkg::KIND_NONE;
               lead_tok.start = pend_ff;
               lead_tok.len   = span(pend_ff, pos_ff);
               fresh          = 1'b1;
            end
         end
         ctee_pkg::LX_IDLE: begin
            fresh = 1'b1;
         end
         default: begin
            fresh = 1'b1;
         end
      endcase

      // Byte that starts something new
      if (fresh) begin
         mode_in         = ctee_pkg::LX_IDLE;
         fresh_tok.kind  = ctee_pkg::KIND_NONE;
         fresh_tok.start = pos_ff;
         fresh_tok.len   = ctee_pkg::POS_W'(1);
         fresh_tok.cls   = ctee_pkg::TC_UNKNOWN;
         if (source_byte == ctee_pkg::CH_NUL) begin
            fresh_v       = 1'b1;
            fresh_tok.cls = ctee_pkg::TC_END;
            ended         = 1'b1;
         end else if (is_space(source_byte)) begin
            fresh_v = 1'b0;
         end else if (source_byte == ctee_pkg::CH_SLASH) begin
            pend_in = pos_ff;
            mode_in = ctee_pkg::LX_SLASH;
         end else if (source_byte == ctee_pkg::CH_QUOTE) begin
            pend_in = sat_inc(pos_ff);
            sib_in  = ctee_pkg::SIB_EMPTY;
            mode_in = ctee_pkg::LX_STR;
         end else if (is_letter(source_byte)) begin
            pend_in = pos_ff;
            km_in   = (source_byte == "e") ? ctee_pkg::KM_ENUM_FIRST :
                      (source_byte == "s") ? ctee_pkg::KM_STRUCT_FIRST : ctee_pkg::KM_NONE;
            mode_in = ctee_pkg::LX_IDENT;
         end else begin
            fresh_v = 1'b1;
            case (source_byte)
               "(":     fresh_tok.cls = ctee_pkg::TC_LPAREN;
               ")":     fresh_tok.cls = ctee_pkg::TC_RPAREN;
               "{":     fresh_tok.cls = ctee_pkg::TC_LBRACE;
               "}":     fresh_tok.cls = ctee_pkg::TC_RBRACE;
               "[":     fresh_tok.cls = ctee_pkg::TC_LBRACKET;
               "]":     fresh_tok.cls = ctee_pkg::TC_RBRACKET;
               ":":     fresh_tok.cls = ctee_pkg::TC_COLON;
               ";":     fresh_tok.cls = ctee_pkg::TC_SEMI;
               "*":     fresh_tok.cls = ctee_pkg::TC_STAR;
               default: fresh_tok.cls = ctee_pkg::TC_UNKNOWN;
            endcase
         end
      end

      // End of text returns the lexer to its reset state
      if (ended) begin
         mode_in = ctee_pkg::LX_IDLE;
         pos_in  = '0;
         pend_in = '0;
         km_in   = ctee_pkg::KM_NONE;
         sib_in  = ctee_pkg::SIB_EMPTY;
      end else begin
         pos_in = sat_inc(pos_ff);
      end
   end

   // Pack the byte's tokens into one queue entry
   assign push       = accept && (lead_v || fresh_v);
   assign entry.two  = lead_v && fresh_v;
   assign entry.tok0 = lead_v ? lead_tok : fresh_tok;
   assign entry.tok1 = fresh_tok;

   // Lexer state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ctee_pkg::LX_IDLE;
         pos_ff  <= '0;
         pend_ff <= '0;
         km_ff   <= ctee_pkg::KM_NONE;
         sib_ff  <= ctee_pkg::SIB_EMPTY;
      end else if (accept) begin
         mode_ff <= mode_in;
         pos_ff  <= pos_in;
         pend_ff <= pend_in;
         km_ff   <= km_in;
         sib_ff  <= sib_in;
      end
   end

endmodule

>>> rtl/ctee_queue.sv
// Short token queue that decouples the lexer from the parser.
module ctee_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  ctee_pkg::entry_type      push_entry,
   input  logic                     pop,
   output logic                     full,
   output ctee_pkg::queue_out_type  head
);

   ctee_pkg::entry_type                 slots_ff [ctee_pkg::QUEUE_DEPTH];
   logic [ctee_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [ctee_pkg::QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [ctee_pkg::QCNT_W-1:0]         count_ff, count_in;
   logic                                do_push, do_pop;

   assign full       = (count_ff == ctee_pkg::QCNT_W'(ctee_pkg::QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.entry = slots_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head.valid;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == ctee_pkg::QPTR_W'(ctee_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                                : wr_ptr_ff + 1'b1;
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == ctee_pkg::QPTR_W'(ctee_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                                : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) slots_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

>>> rtl/ctee_parser.sv
// Back part: enum recognizer that marks tokens and drives the record register.
module ctee_parser (
   input  logic                               clock,
   input  logic                               reset,
   input  ctee_pkg::queue_out_type            head,
   output logic                               pop,
   input  logic                               out_ready,
   output logic                               out_valid,
   output ctee_pkg::lex_token_type            out_tok,
   output ctee_pkg::enum_role_type            out_role,
   output logic [ctee_pkg::POS_W-1:0]         out_name_start,
   output logic [ctee_pkg::POS_W-1:0]         out_name_len,
   output logic                               out_last
);

   ctee_pkg::parser_mode_type       mode_ff, mode_in;
   logic [ctee_pkg::POS_W-1:0]      held_start_ff, held_start_in;
   logic [ctee_pkg::POS_W-1:0]      held_len_ff, held_len_in;
   logic                            sel_ff;
   logic                            valid_ff;
   ctee_pkg::lex_token_type         tok_ff;
   ctee_pkg::enum_role_type         role_ff, role_in;
   logic [ctee_pkg::POS_W-1:0]      name_start_ff, name_len_ff;
   logic                            last_ff;

   ctee_pkg::lex_token_type         tok;
   logic                            tok_last, load, named, brace;

   // Current token of the head entry
   assign tok      = sel_ff ? head.entry.tok1 : head.entry.tok0;
   assign tok_last = !head.entry.two || sel_ff;
   assign load     = head.valid && (!valid_ff || out_ready);
   assign pop      = load && tok_last;
   assign brace    = (tok.cls == ctee_pkg::TC_LBRACE) || (tok.kind == ctee_pkg::KIND_BRACE);

   // Recognizer next state and role of the token
   always_comb begin
      mode_in       = mode_ff;
      held_start_in = held_start_ff;
      held_len_in   = held_len_ff;
      role_in       = ctee_pkg::ROLE_PLAIN;
      named         = 1'b0;
      unique case (mode_ff)
         ctee_pkg::PM_IDLE: begin
            if (tok.kind == ctee_pkg::KIND_ENUM) mode_in = ctee_pkg::PM_AFTER_ENUM;
            else if (tok.kind == ctee_pkg::KIND_STRUCT) mode_in = ctee_pkg::PM_AFTER_STRUCT;
         end
         ctee_pkg::PM_AFTER_ENUM: begin
            if (tok.cls == ctee_pkg::TC_IDENT) begin
               held_start_in = tok.start;
               held_len_in   = tok.len;
               mode_in       = ctee_pkg::PM_ENUM_NAMED;
            end else begin
               mode_in = ctee_pkg::PM_IDLE;
            end
         end
         ctee_pkg::PM_ENUM_NAMED: begin
            if (brace) begin
               role_in = ctee_pkg::ROLE_OPEN;
               named   = 1'b1;
               mode_in = ctee_pkg::PM_ENUM_BODY;
            end else begin
               mode_in = ctee_pkg::PM_IDLE;
            end
         end
         ctee_pkg::PM_ENUM_BODY: begin
            if (tok.cls == ctee_pkg::TC_RBRACE) begin
               role_in = ctee_pkg::ROLE_CLOSE;
               mode_in = ctee_pkg::PM_IDLE;
            end else if (tok.cls == ctee_pkg::TC_IDENT) begin
               role_in = ctee_pkg::ROLE_MEMBER;
            end else if (tok.cls == ctee_pkg::TC_END) begin
               role_in = ctee_pkg::ROLE_END;
            end
         end
         ctee_pkg::PM_AFTER_STRUCT: begin
            mode_in = (tok.cls == ctee_pkg::TC_IDENT) ? ctee_pkg::PM_STRUCT_NAMED
                                                      : ctee_pkg::PM_IDLE;
         end
         default: begin
            mode_in = ctee_pkg::PM_IDLE;
         end
      endcase
      // End of text returns the recognizer to reset
      if (tok.cls == ctee_pkg::TC_END) begin
         mode_in       = ctee_pkg::PM_IDLE;
         held_start_in = '0;
         held_len_in   = '0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= ctee_pkg::PM_IDLE;
         held_start_ff <= '0;
         held_len_ff   <= '0;
         sel_ff        <= 1'b0;
         valid_ff      <= 1'b0;
      end else begin
         if (load) begin
            mode_ff       <= mode_in;
            held_start_ff <= held_start_in;
            held_len_ff   <= held_len_in;
            sel_ff        <= !tok_last;
         end
         if (load) valid_ff <= 1'b1;
         else if (out_ready) valid_ff <= 1'b0;
      end
   end

   // Record register
   always_ff @(posedge clock) begin
      if (load) begin
         tok_ff        <= tok;
         role_ff       <= role_in;
         name_start_ff <= named ? held_start_ff : '0;
         name_len_ff   <= named ? held_len_ff : '0;
         last_ff       <= tok_last;
      end
   end

   assign out_valid      = valid_ff;
   assign out_tok        = tok_ff;
   assign out_role       = role_ff;
   assign out_name_start = name_start_ff;
   assign out_name_len   = name_len_ff;
   assign out_last       = last_ff;

endmodule

>>> rtl/c_tokenizer_enum_extractor.sv
// Top level of the C tokenizer with enum extractor.
//
// The req channel carries source text, one byte per transaction; a zero byte
// ends a text. The rsp channel carries one token record per transaction:
// class and enum role in tuser, positions and lengths in tdata, and tlast on
// the final record caused by one source byte.
// The lexer takes a byte in every cycle in which the four-entry token queue
// has room. A byte causes zero, one or two records; the parser stage hands
// out one record per cycle while rsp_tready is high, so a byte with two
// records holds the output side for both while the queue keeps the input
// side running. A record passes through the token queue and then the record
// register before it reaches rsp; the second record of a byte follows the first.
// Throughput: one byte per cycle while the queue has room, limited by one
// record per cycle at the record register while rsp_tready is high.
// When rsp_tready is low the record register holds, the queue fills and
// req_tready drops once it is full; nothing is lost.
// Reset (synchronous, active high) clears the lexer, queue, recognizer and
// record valid flag; position counting restarts at zero. The zero byte does
// the same to lexer and recognizer state after its end record.
module c_tokenizer_enum_extractor (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: source_byte[7:0]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ctee_pkg::REQ_DATA_W-1:0]     req_tdata,
   // rsp_tdata: token_start[20:0], token_length[41:21], enum_name_start[62:42],
   //            enum_name_length[83:63], zero fill[87:84]
   // rsp_tuser: token_class[3:0], enum_role[6:4]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ctee_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [ctee_pkg::RSP_USER_W-1:0]     rsp_tuser,
   output logic                                rsp_tlast
);

   logic                            accept;
   logic                            push;
   logic                            pop;
   logic                            full;
   ctee_pkg::entry_type             push_entry;
   ctee_pkg::queue_out_type         head;
   ctee_pkg::lex_token_type         out_tok;
   ctee_pkg::enum_role_type         out_role;
   logic [ctee_pkg::POS_W-1:0]      out_name_start;
   logic [ctee_pkg::POS_W-1:0]      out_name_len;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   ctee_lexer u_lexer (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .source_byte (req_tdata),
      .push        (push),
      .entry       (push_entry)
   );

   ctee_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (full),
      .head       (head)
   );

   ctee_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .pop            (pop),
      .out_ready      (rsp_tready),
      .out_valid      (rsp_tvalid),
      .out_tok        (out_tok),
      .out_role       (out_role),
      .out_name_start (out_name_start),
      .out_name_len   (out_name_len),
      .out_last       (rsp_tlast)
   );

   // Record packing
   assign rsp_tdata = {4'b0000, out_name_len, out_name_start, out_tok.len, out_tok.start};
   assign rsp_tuser = {out_role, out_tok.cls};

endmodule

>>> rtl/ctee_checker.sv
// Port-level checks of the C tokenizer with enum extractor, bound to the top level.
module ctee_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [ctee_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input logic [ctee_pkg::RSP_USER_W-1:0]     rsp_tuser,
   input logic                                rsp_tlast
);

   // A stalled record holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp record changed while stalled");

   // No record right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   // End of text is always the final record of its byte
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[3:0] == ctee_pkg::TC_END |-> rsp_tlast)
      else $error("end record without tlast");

   // Enum name only shows with an opened body, which comes from a brace or string
   a_name_open: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[6:4] != ctee_pkg::ROLE_OPEN |-> rsp_tdata[83:42] == '0)
      else $error("enum name outside body open");

   a_open_class: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[6:4] == ctee_pkg::ROLE_OPEN |->
         rsp_tuser[3:0] == ctee_pkg::TC_LBRACE || rsp_tuser[3:0] == ctee_pkg::TC_STRING)
      else $error("enum body opened by wrong token class");

endmodule

bind c_tokenizer_enum_extractor ctee_checker u_ctee_checker (.*);

>>> tb/sv/tb.sv
// Testbench for the C tokenizer with enum extractor: source text stream in, token records out.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int RANDOM_BYTES = 650;
   localparam int HOLD_AT      = 200;
   localparam int HOLD_CYCLES  = 120;
   localparam int DRAIN_CYCLES = 20;
   localparam int PRINT_CAP    = 100;
   localparam int POS_W        = ctee_pkg::POS_W;

   // One expected token record
   typedef struct {
      ctee_pkg::token_class_type cls;
      logic [POS_W-1:0]          start;
      logic [POS_W-1:0]          len;
      ctee_pkg::enum_role_type   role;
      logic [POS_W-1:0]          name_start;
      logic [POS_W-1:0]          name_len;
      logic                      last;
   } token_record_type;

   // Lexer/recognizer predictor plus the store of records still owed by the block
   class token_checker;
      token_record_type          owed_records[$];
      int                        mismatches;
      int                        bytes_taken;
      int                        records_seen;

      ctee_pkg::lexer_mode_type  lx;
      ctee_pkg::parser_mode_type pm;
      logic [POS_W-1:0]          pos;
      logic [POS_W-1:0]          pend;
      logic [3:0]                km;
      logic [1:0]                sib;
      logic [POS_W-1:0]          name_start;
      logic [POS_W-1:0]          name_len;

      function new();
         clear_state();
      endfunction

      function void clear_state();
         lx         = ctee_pkg::LX_IDLE;
         pm         = ctee_pkg::PM_IDLE;
         pos        = '0;
         pend       = '0;
         km         = ctee_pkg::KM_NONE;
         sib        = ctee_pkg::SIB_EMPTY;
         name_start = '0;
         name_len   = '0;
      endfunction

      function int pending();
         return owed_records.size();
      endfunction

      function logic [POS_W-1:0] sat_inc(logic [POS_W-1:0] p);
         return (p >= ctee_pkg::POS_LIMIT) ? ctee_pkg::POS_LIMIT : p + 1'b1;
      endfunction

      function logic [POS_W-1:0] span(logic [POS_W-1:0] st, logic [POS_W-1:0] at);
         return (at >= st) ? at - st : '0;
      endfunction

      function bit is_letter(logic [7:0] c);
         return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      endfunction

      function bit is_word_char(logic [7:0] c);
         return is_letter(c) || (c >= "0" && c <= "9") || c == ctee_pkg::CH_UNDER;
      endfunction

      function bit is_blank(logic [7:0] c);
         return c == " " || (c >= 8'd9 && c <= 8'd13);
      endfunction

      function bit punct_of(logic [7:0] c, output ctee_pkg::token_class_type cls);
         cls = ctee_pkg::TC_UNKNOWN;
         case (c)
            "(": cls = ctee_pkg::TC_LPAREN;
            ")": cls = ctee_pkg::TC_RPAREN;
            "{": cls = ctee_pkg::TC_LBRACE;
            "}": cls = ctee_pkg::TC_RBRACE;
            "[": cls = ctee_pkg::TC_LBRACKET;
            "]": cls = ctee_pkg::TC_RBRACKET;
            ":": cls = ctee_pkg::TC_COLON;
            ";": cls = ctee_pkg::TC_SEMI;
            "*": cls = ctee_pkg::TC_STAR;
            default: return 1'b0;
         endcase
         return 1'b1;
      endfunction

      // Keyword progress while an identifier is scanned
      function logic [3:0] keyword_step(logic [3:0] m, logic [7:0] c);
         logic [2:0] sidx;
         sidx = 3'(m - (ctee_pkg::KM_STRUCT_FIRST - 4'd1));
         if (m >= ctee_pkg::KM_ENUM_FIRST && m <= ctee_pkg::KM_ENUM_LAST)
            return (c == ctee_pkg::KW_ENUM[m[1:0]]) ? 4'(m + 4'd1) : ctee_pkg::KM_NONE;
         if (m >= ctee_pkg::KM_STRUCT_FIRST && m <= ctee_pkg::KM_STRUCT_LAST)
            return (c == ctee_pkg::KW_STRUCT[sidx]) ? 4'(m + 4'd1) : ctee_pkg::KM_NONE;
         return ctee_pkg::KM_NONE;
      endfunction

      // Enum recognizer: tags the token and queues its record
      function void owe_token(ctee_pkg::token_class_type cls, ctee_pkg::token_kind_type kind,
                              logic [POS_W-1:0] st, logic [POS_W-1:0] ln);
         token_record_type r;
         bit brace;
         r.cls        = cls;
         r.start      = st;
         r.len        = ln;
         r.role       = ctee_pkg::ROLE_PLAIN;
         r.name_start = '0;
         r.name_len   = '0;
         r.last       = 1'b0;
         brace = (cls == ctee_pkg::TC_LBRACE) || (kind == ctee_pkg::KIND_BRACE);
         case (pm)
            ctee_pkg::PM_IDLE: begin
               if (kind == ctee_pkg::KIND_ENUM) pm = ctee_pkg::PM_AFTER_ENUM;
               else if (kind == ctee_pkg::KIND_STRUCT) pm = ctee_pkg::PM_AFTER_STRUCT;
            end
            ctee_pkg::PM_AFTER_ENUM: begin
               if (cls == ctee_pkg::TC_IDENT) begin
                  name_start = st;
                  name_len   = ln;
                  pm         = ctee_pkg::PM_ENUM_NAMED;
               end else begin
                  pm = ctee_pkg::PM_IDLE;
               end
            end
            ctee_pkg::PM_ENUM_NAMED: begin
               if (brace) begin
                  r.role       = ctee_pkg::ROLE_OPEN;
                  r.name_start = name_start;
                  r.name_len   = name_len;
                  pm           = ctee_pkg::PM_ENUM_BODY;
               end else begin
                  pm = ctee_pkg::PM_IDLE;
               end
            end
            ctee_pkg::PM_ENUM_BODY: begin
               if (cls == ctee_pkg::TC_RBRACE) begin
                  r.role = ctee_pkg::ROLE_CLOSE;
                  pm     = ctee_pkg::PM_IDLE;
               end else if (cls == ctee_pkg::TC_IDENT) begin
                  r.role = ctee_pkg::ROLE_MEMBER;
               end else if (cls == ctee_pkg::TC_END) begin
                  r.role = ctee_pkg::ROLE_END;
               end
            end
            ctee_pkg::PM_AFTER_STRUCT:
               pm = (cls == ctee_pkg::TC_IDENT) ? ctee_pkg::PM_STRUCT_NAMED : ctee_pkg::PM_IDLE;
            default: pm = ctee_pkg::PM_IDLE;
         endcase
         owed_records.push_back(r);
      endfunction

      // Lex one accepted source byte and queue the records it causes
      function void lex_byte(logic [7:0] c);
         logic [POS_W-1:0]          at;
         ctee_pkg::token_class_type pc;
         ctee_pkg::token_kind_type  kind;
         int                        before_cnt;
         bit                        fresh;
         bit                        ended;
         at         = pos;
         before_cnt = owed_records.size();
         fresh      = 1'b0;
         ended      = 1'b0;
         bytes_taken++;
         case (lx)
            ctee_pkg::LX_SLASH: begin
               if (c == ctee_pkg::CH_SLASH) lx = ctee_pkg::LX_LINE;
               else if (c == ctee_pkg::CH_STAR) lx = ctee_pkg::LX_BLOCK;
               else begin
                  owe_token(ctee_pkg::TC_UNKNOWN, ctee_pkg::KIND_NONE, pend, POS_W'(1));
                  fresh = 1'b1;
               end
            end
            ctee_pkg::LX_LINE: begin
               if (c == ctee_pkg::CH_NUL) fresh = 1'b1;
               else if (c == ctee_pkg::CH_LF) lx = ctee_pkg::LX_IDLE;
            end
            ctee_pkg::LX_BLOCK: begin
               if (c == ctee_pkg::CH_NUL) fresh = 1'b1;
               else if (c == ctee_pkg::CH_STAR) lx = ctee_pkg::LX_BLOCK_STAR;
            end
            ctee_pkg::LX_BLOCK_STAR: begin
               if (c == ctee_pkg::CH_NUL) fresh = 1'b1;
               else if (c == ctee_pkg::CH_SLASH) lx = ctee_pkg::LX_IDLE;
               else if (c != ctee_pkg::CH_STAR) lx = ctee_pkg::LX_BLOCK;
            end
            ctee_pkg::LX_STR, ctee_pkg::LX_STR_ESC: begin
               if (c == ctee_pkg::CH_NUL || (c == ctee_pkg::CH_QUOTE && lx == ctee_pkg::LX_STR))
               begin
                  kind = (sib == ctee_pkg::SIB_BRACE) ? ctee_pkg::KIND_BRACE
                                                      : ctee_pkg::KIND_NONE;
                  owe_token(ctee_pkg::TC_STRING, kind, pend, span(pend, at));
                  lx    = ctee_pkg::LX_IDLE;
                  fresh = (c == ctee_pkg::CH_NUL);
               end else if (lx == ctee_pkg::LX_STR && c == ctee_pkg::CH_BSLASH) begin
                  sib = ctee_pkg::SIB_OTHER;
                  lx  = ctee_pkg::LX_STR_ESC;
               end else begin
                  sib = (sib == ctee_pkg::SIB_EMPTY && c == ctee_pkg::CH_LBRACE &&
                         lx == ctee_pkg::LX_STR) ? ctee_pkg::SIB_BRACE : ctee_pkg::SIB_OTHER;
                  lx  = ctee_pkg::LX_STR;
               end
            end
            ctee_pkg::LX_IDENT: begin
               if (is_word_char(c)) begin
                  km = keyword_step(km, c);
               end else begin
                  kind = (km == ctee_pkg::KM_ENUM_DONE) ? ctee_pkg::KIND_ENUM :
                         (km == ctee_pkg::KM_STRUCT_DONE) ? ctee_pkg::KIND_STRUCT :
                                                            ctee_pkg::KIND_NONE;
                  owe_token(ctee_pkg::TC_IDENT, kind, pend, span(pend, at));
                  fresh = 1'b1;
               end
            end
            default: fresh = 1'b1;
         endcase

         // Byte that starts something new
         if (fresh) begin
            lx = ctee_pkg::LX_IDLE;
            if (c == ctee_pkg::CH_NUL) begin
               owe_token(ctee_pkg::TC_END, ctee_pkg::KIND_NONE, at, POS_W'(1));
               ended = 1'b1;
            end else if (is_blank(c)) begin
               // whitespace between tokens
            end else if (c == ctee_pkg::CH_SLASH) begin
               pend = at;
               lx   = ctee_pkg::LX_SLASH;
            end else if (c == ctee_pkg::CH_QUOTE) begin
               pend = sat_inc(at);
               sib  = ctee_pkg::SIB_EMPTY;
               lx   = ctee_pkg::LX_STR;
            end else if (is_letter(c)) begin
               pend = at;
               km   = (c == ctee_pkg::KW_ENUM[0]) ? ctee_pkg::KM_ENUM_FIRST :
                      (c == ctee_pkg::KW_STRUCT[0]) ? ctee_pkg::KM_STRUCT_FIRST :
                                                      ctee_pkg::KM_NONE;
               lx   = ctee_pkg::LX_IDENT;
            end else if (punct_of(c, pc)) begin
               owe_token(pc, ctee_pkg::KIND_NONE, at, POS_W'(1));
            end else begin
               owe_token(ctee_pkg::TC_UNKNOWN, ctee_pkg::KIND_NONE, at, POS_W'(1));
            end
         end

         if (owed_records.size() > before_cnt)
            owed_records[owed_records.size() - 1].last = 1'b1;
         if (ended) clear_state();
         else pos = sat_inc(at);
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= PRINT_CAP)
            $display("[%0t] mismatch %0d: %s", $realtime, mismatches, msg);
      endtask

      // Compare one accepted record against the oldest owed one
      task check_record(logic [ctee_pkg::RSP_DATA_W-1:0] data,
                        logic [ctee_pkg::RSP_USER_W-1:0] user, logic last);
         token_record_type want;
         logic [3:0]       got_cls;
         logic [2:0]       got_role;
         logic [POS_W-1:0] got_start, got_len, got_nst, got_nln;
         got_cls   = user[3:0];
         got_role  = user[6:4];
         got_start = data[POS_W-1:0];
         got_len   = data[2*POS_W-1:POS_W];
         got_nst   = data[3*POS_W-1:2*POS_W];
         got_nln   = data[4*POS_W-1:3*POS_W];
         records_seen++;
         if (owed_records.size() == 0) begin
            report($sformatf("record %0d unexpected: cls %0d start %0d len %0d",
                             records_seen, got_cls, got_start, got_len));
            return;
         end
         want = owed_records.pop_front();
         if (got_cls !== want.cls || got_role !== want.role || got_start !== want.start ||
             got_len !== want.len || got_nst !== want.name_start ||
             got_nln !== want.name_len || last !== want.last)
            report($sformatf({"record %0d got cls %0d role %0d start %0d len %0d ",
                              "name %0d/%0d last %0b; want cls %0d role %0d start %0d ",
                              "len %0d name %0d/%0d last %0b"},
                             records_seen, got_cls, got_role, got_start, got_len,
                             got_nst, got_nln, last, want.cls, want.role, want.start,
                             want.len, want.name_start, want.name_len, want.last));
      endtask
   endclass

   logic                            clock;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [ctee_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [ctee_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [ctee_pkg::RSP_USER_W-1:0] rsp_tuser;
   logic                            rsp_tlast;

   token_checker sb = new();
   logic [7:0]   source_q[$];
   logic [7:0]   last_sent = 8'hff;
   bit           send_quiet = 1'b0;
   int           cycle_count = 0;

   c_tokenizer_enum_extractor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ---- source text builders ----
   function void put(logic [7:0] b);
      source_q.push_back(b);
   endfunction

   function void put_str(string s);
      foreach (s[i]) put(s[i]);
   endfunction

   function logic [7:0] rand_letter();
      int v;
      v = $urandom_range(0, 51);
      return (v < 26) ? 8'("a" + v) : 8'("A" + v - 26);
   endfunction

   function logic [7:0] rand_word_char();
      int v;
      v = $urandom_range(0, 62);
      if (v < 52) return rand_letter();
      if (v < 62) return 8'("0" + v - 52);
      return ctee_pkg::CH_UNDER;
   endfunction

   function logic [7:0] rand_text_char();
      if ($urandom_range(0, 3) == 0) return 8'($urandom_range(1, 255));
      return 8'($urandom_range(32, 126));
   endfunction

   function void put_blank();
      case ($urandom_range(0, 5))
         0: put(" ");
         1: put(8'd9);
         2: put(ctee_pkg::CH_LF);
         3: put(8'd11);
         4: put(8'd12);
         default: put(8'd13);
      endcase
   endfunction

   function void maybe_blank();
      if ($urandom_range(0, 9) < 6) put_blank();
   endfunction

   function void put_name();
      int n;
      n = $urandom_range(0, 5);
      put(rand_letter());
      repeat (n) put(rand_word_char());
   endfunction

   function void put_ident();
      case ($urandom_range(0, 9))
         0: put_str("enum");
         1: put_str("struct");
         2: put_str("enu");
         3: put_str("structx");
         4: put_str("enums");
         5: put_str("_t");
         default: put_name();
      endcase
   endfunction

   function void put_punct();
      string marks;
      marks = "(){}[]:;*";
      put(marks[$urandom_range(0, 8)]);
   endfunction

   function void put_string_lit();
      int n;
      put(ctee_pkg::CH_QUOTE);
      if ($urandom_range(0, 3) == 0) begin
         put(ctee_pkg::CH_LBRACE);
      end else begin
         n = $urandom_range(0, 5);
         repeat (n) begin
            if ($urandom_range(0, 5) == 0) begin
               put(ctee_pkg::CH_BSLASH);
               put(8'($urandom_range(1, 255)));
            end else begin
               put(rand_text_char());
            end
         end
      end
      if ($urandom_range(0, 9) != 0) put(ctee_pkg::CH_QUOTE);
   endfunction

   function void put_comment();
      int n;
      n = $urandom_range(0, 4);
      put(ctee_pkg::CH_SLASH);
      if ($urandom_range(0, 1) == 0) begin
         put(ctee_pkg::CH_SLASH);
         repeat (n) put(rand_text_char());
         put(ctee_pkg::CH_LF);
      end else begin
         put(ctee_pkg::CH_STAR);
         repeat (n) put(($urandom_range(0, 3) == 0) ? ctee_pkg::CH_STAR : rand_text_char());
         if ($urandom_range(0, 9) != 0) begin
            put(ctee_pkg::CH_STAR);
            put(ctee_pkg::CH_SLASH);
         end
      end
   endfunction

   // enum NAME { members } with occasional broken heads and a brace written as a string
   function void put_enum();
      int n;
      put_str("enum");
      put_blank();
      if ($urandom_range(0, 7) == 0) put_punct();
      else put_name();
      maybe_blank();
      if ($urandom_range(0, 4) == 0) put_str("\"{\"");
      else if ($urandom_range(0, 7) == 0) put_name();
      else put(ctee_pkg::CH_LBRACE);
      n = $urandom_range(0, 4);
      repeat (n) begin
         maybe_blank();
         put_ident();
         if ($urandom_range(0, 2) == 0) begin
            put_str(" = ");
            put(8'("0" + $urandom_range(0, 9)));
         end
         if ($urandom_range(0, 5) == 0) put_comment();
         put(",");
      end
      maybe_blank();
      if ($urandom_range(0, 7) != 0) put("}");
      put(";");
   endfunction

   function void put_struct();
      put_str("struct");
      put_blank();
      put_name();
      maybe_blank();
      put(ctee_pkg::CH_LBRACE);
      put_name();
      put_blank();
      put_name();
      put(";");
      put("}");
      put(";");
   endfunction

   function void build_text();
      int frags;
      int pick;
      frags = $urandom_range(3, 12);
      repeat (frags) begin
         pick = $urandom_range(0, 99);
         if (pick < 20) put_enum();
         else if (pick < 28) put_struct();
         else if (pick < 43) put_ident();
         else if (pick < 58) put_punct();
         else if (pick < 67) put_string_lit();
         else if (pick < 80) put_comment();
         else if (pick < 86) put(ctee_pkg::CH_SLASH);
         else put(8'($urandom_range(1, 255)));
         maybe_blank();
      end
      if ($urandom_range(0, 6) != 0) put(ctee_pkg::CH_NUL);
   endfunction

   // ---- source side ----
   task send_byte(logic [7:0] b);
      int gap;
      gap = send_quiet ? 0 : $urandom_range(0, 6);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.lex_byte(b);
      last_sent = b;
   endtask

   task play_source();
      while (source_q.size() > 0) send_byte(source_q.pop_front());
   endtask

   initial begin : source_side
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: brace string opening an enum body, end inside the body,
      // lone slash, wide byte, unterminated string with a trailing backslash,
      // unterminated comment
      put_str("enum E\"{\"q");
      put(ctee_pkg::CH_NUL);
      put_str("/;");
      put(8'hff);
      put(ctee_pkg::CH_QUOTE);
      put(ctee_pkg::CH_BSLASH);
      put(ctee_pkg::CH_NUL);
      put_str("/*");
      put(ctee_pkg::CH_NUL);
      play_source();

      // Random texts, mostly well-formed C fragments
      while (sb.bytes_taken < RANDOM_BYTES) begin
         send_quiet = ($urandom_range(0, 4) == 0);
         build_text();
         play_source();
      end
      if (last_sent != ctee_pkg::CH_NUL) send_byte(ctee_pkg::CH_NUL);
      @(negedge clock);
      req_tvalid <= 1'b0;

      // Drain
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // ---- record side ----
   initial begin : record_side
      int gap;
      bit quiet;
      bit held;
      quiet = 1'b0;
      held  = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         // one long hold-off lets the token queue fill and stall the source
         if (!held && sb.bytes_taken >= HOLD_AT) begin
            held = 1'b1;
            gap  = HOLD_CYCLES;
         end else begin
            gap = quiet ? 0 : $urandom_range(0, 6);
         end
         if ($urandom_range(0, 29) == 0) quiet = !quiet;
         @(negedge clock);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         sb.check_record(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

endmodule

>>> filelist.f
rtl/ctee_pkg.sv
rtl/ctee_lexer.sv
rtl/ctee_queue.sv
rtl/ctee_parser.sv
rtl/c_tokenizer_enum_extractor.sv
rtl/ctee_checker.sv
tb/sv/tb.sv
